// ===== src/dvr_pkg.sv =====
package dvr_pkg;

   // Router count; the design holds for 2 to 15.
   localparam int NUM_ROUTERS = 8;
   localparam int IDX_W       = (NUM_ROUTERS > 1) ? $clog2(NUM_ROUTERS) : 1;
   localparam int VEC_DEPTH   = NUM_ROUTERS * NUM_ROUTERS;
   localparam int ADDR_W      = $clog2(VEC_DEPTH);
   localparam int COST_W      = 9;

   localparam logic [COST_W-1:0] NO_COST       = '1;
   localparam logic [8:0]        MAX_PATH_COST = 9'd100;

   typedef enum logic [1:0] {
      FUNC_LINK      = 2'd0,
      FUNC_VECTOR    = 2'd1,
      FUNC_RECOMPUTE = 2'd2,
      FUNC_NONE      = 2'd3
   } func_type;

   // Bit 8 set means unknown; otherwise bits 7:0 hold the cost.
   function automatic logic [COST_W-1:0] norm_cost(input logic [COST_W-1:0] raw);
      norm_cost = raw[COST_W-1] ? NO_COST : raw;
   endfunction

endpackage

// ===== src/dvr_ram.sv =====
module dvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/distance_vector_route_update_core.sv =====
// Distance-vector routing table, Bellman-Ford update.
// Command channel: start with req_func/req_neighbor/req_destination/req_cost is
// taken at a clock edge where busy is low. Link cost and vector entry writes
// finish at that edge and leave busy low, so they can come every cycle.
// A recompute walks every (destination, neighbor) pair, one pair per cycle
// through the single adder/comparator and the vector RAM read port, and
// emits one word per destination on the rsp_ ports, each marked by a
// one-cycle rsp_valid strobe. Destination d's word follows its last
// neighbor pair through the pair stage and the rsp_ registers; a recompute
// holds busy through the walk, the last word arriving the cycle busy drops.
// rsp_last_entry marks the final word, which carries rsp_table_changed.
// The receiver cannot stall; words are simply presented for one cycle.
// csr_wr_en/csr_wr_data set the own router number at any edge.
// After reset the block clears the vector RAM, one entry a cycle, holding
// busy until every entry is cleared; csr writes still land.
// Reset sets link costs, vectors and routes to unknown and self_id to 1.
module distance_vector_route_update_core
   import dvr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_neighbor,
   input  logic [3:0]        req_destination,
   input  logic signed [8:0] req_cost,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   output logic              rsp_valid,
   output logic [3:0]        rsp_route_destination,
   output logic signed [7:0] rsp_route_cost,
   output logic signed [4:0] rsp_next_hop,
   output logic              rsp_last_entry,
   output logic              rsp_table_changed
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VEC_DEPTH - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_ROUTERS - 1);

   state_type         state_ff, state_in;
   logic [3:0]        self_id_ff, self_id_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]  n_ff, n_in, d_ff, d_in;
   logic [COST_W-1:0] link_ff [NUM_ROUTERS];
   logic [COST_W-1:0] link_in [NUM_ROUTERS];
   logic [7:0]        rcost_ff [NUM_ROUTERS];
   logic [7:0]        rcost_in [NUM_ROUTERS];
   logic [4:0]        rhop_ff [NUM_ROUTERS];
   logic [4:0]        rhop_in [NUM_ROUTERS];

   // pair stage, in step with the RAM read data
   logic              s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]  s1_n_ff, s1_n_in, s1_d_ff, s1_d_in;
   logic [COST_W-1:0] s1_lc_ff, s1_lc_in;
   logic              s1_skip_ff, s1_skip_in;
   logic              s1_self_dst_ff, s1_self_dst_in;
   logic              s1_last_n_ff, s1_last_n_in;
   logic              s1_last_d_ff, s1_last_d_in;

   // running minimum for the current destination
   logic [6:0]        best_ff, best_in;
   logic              best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]  hop_ff, hop_in;
   logic              changed_ff, changed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_dst_ff, rsp_dst_in;
   logic [7:0]        rsp_cost_ff, rsp_cost_in;
   logic [4:0]        rsp_hop_ff, rsp_hop_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_chg_ff, rsp_chg_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [COST_W-1:0] ram_wr_data;
   logic [COST_W-1:0] adv;

   logic              accept;
   logic              nb_ok, dst_ok;
   logic [4:0]        nb_m1, dst_m1;
   logic [IDX_W-1:0]  nb_idx;
   logic [COST_W-1:0] cost_norm;

   logic [8:0]        sum;
   logic              cand_ok, cur_vld, take;
   logic [7:0]        fin_cost;
   logic [4:0]        fin_hop;
   logic              entry_chg;

   dvr_ram #(
      .WIDTH(COST_W),
      .DEPTH(VEC_DEPTH)
   ) u_vec_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(addr_ff),
      .rd_data(adv)
   );

   assign busy      = (state_ff != ST_IDLE) || s1_vld_ff;
   assign accept    = start && !busy;
   assign nb_ok     = (req_neighbor != 4'd0) && (32'(req_neighbor) <= NUM_ROUTERS);
   assign dst_ok    = (req_destination != 4'd0) && (32'(req_destination) <= NUM_ROUTERS);
   assign nb_m1     = {1'b0, req_neighbor} - 5'd1;
   assign dst_m1    = {1'b0, req_destination} - 5'd1;
   assign nb_idx    = IDX_W'(nb_m1);
   assign cost_norm = norm_cost(req_cost);

   // vector RAM is destination-major so the recompute reads it in order
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = addr_ff;
         ram_wr_data = NO_COST;
      end else begin
         ram_wr_en   = accept && (func_type'(req_func) == FUNC_VECTOR) && nb_ok && dst_ok;
         ram_wr_addr = ADDR_W'(32'(dst_m1) * NUM_ROUTERS + 32'(nb_m1));
         ram_wr_data = cost_norm;
      end
   end

   // candidate from the pair stage
   always_comb begin
      sum      = {1'b0, s1_lc_ff[7:0]} + {1'b0, adv[7:0]};
      cand_ok  = !s1_skip_ff && !s1_lc_ff[8] && !adv[8] && (sum <= MAX_PATH_COST);
      cur_vld  = (s1_n_ff != '0) && best_vld_ff;
      take     = cand_ok && (!cur_vld || (sum[6:0] < best_ff));
      if (s1_self_dst_ff) begin
         fin_cost = 8'd0;
         fin_hop  = {1'b0, self_id_ff};
      end else if (take) begin
         fin_cost = {1'b0, sum[6:0]};
         fin_hop  = 5'(s1_n_ff) + 5'd1;
      end else if (cur_vld) begin
         fin_cost = {1'b0, best_ff};
         fin_hop  = 5'(hop_ff) + 5'd1;
      end else begin
         fin_cost = 8'hFF;
         fin_hop  = 5'h1F;
      end
      entry_chg = (rcost_ff[s1_d_ff] != fin_cost) || (rhop_ff[s1_d_ff] != fin_hop);
   end

   always_comb begin
      state_in       = state_ff;
      self_id_in     = csr_wr_en ? csr_wr_data : self_id_ff;
      addr_in        = addr_ff;
      n_in           = n_ff;
      d_in           = d_ff;
      link_in        = link_ff;
      rcost_in       = rcost_ff;
      rhop_in        = rhop_ff;
      s1_vld_in      = 1'b0;
      s1_n_in        = n_ff;
      s1_d_in        = d_ff;
      s1_lc_in       = link_ff[n_ff];
      s1_skip_in     = (32'(n_ff) + 1 == 32'(self_id_ff));
      s1_self_dst_in = (32'(d_ff) + 1 == 32'(self_id_ff));
      s1_last_n_in   = (n_ff == LAST_IDX);
      s1_last_d_in   = (d_ff == LAST_IDX);
      best_in        = best_ff;
      best_vld_in    = best_vld_ff;
      hop_in         = hop_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = 1'b0;
      rsp_dst_in     = rsp_dst_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_chg_in     = rsp_chg_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_LINK: begin
                     if (nb_ok) begin
                        link_in[nb_idx] = cost_norm;
                     end
                  end
                  FUNC_RECOMPUTE: begin
                     state_in   = ST_RUN;
                     addr_in    = '0;
                     n_in       = '0;
                     d_in       = '0;
                     changed_in = 1'b0;
                  end
                  default: begin
                     // vector writes go straight to the RAM; func 3 is dropped
                  end
               endcase
            end
         end
         ST_RUN: begin
            s1_vld_in = 1'b1;
            addr_in   = addr_ff + 1'b1;
            n_in      = n_ff + 1'b1;
            if (n_ff == LAST_IDX) begin
               n_in = '0;
               d_in = d_ff + 1'b1;
            end
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (s1_vld_ff) begin
         best_vld_in = cur_vld || take;
         if (take) begin
            best_in = sum[6:0];
            hop_in  = s1_n_ff;
         end
         if (s1_last_n_ff) begin
            rcost_in[s1_d_ff] = fin_cost;
            rhop_in[s1_d_ff]  = fin_hop;
            changed_in        = changed_ff || entry_chg;
            rsp_valid_in      = 1'b1;
            rsp_dst_in        = 4'(s1_d_ff) + 4'd1;
            rsp_cost_in       = fin_cost;
            rsp_hop_in        = fin_hop;
            rsp_last_in       = s1_last_d_ff;
            rsp_chg_in        = s1_last_d_ff && (changed_ff || entry_chg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         self_id_ff   <= 4'd1;
         addr_ff      <= '0;
         n_ff         <= '0;
         d_ff         <= '0;
         s1_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ROUTERS; i++) begin
            link_ff[i]  <= NO_COST;
            rcost_ff[i] <= 8'hFF;
            rhop_ff[i]  <= 5'h1F;
         end
      end else begin
         state_ff     <= state_in;
         self_id_ff   <= self_id_in;
         addr_ff      <= addr_in;
         n_ff         <= n_in;
         d_ff         <= d_in;
         s1_vld_ff    <= s1_vld_in;
         best_vld_ff  <= best_vld_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         link_ff      <= link_in;
         rcost_ff     <= rcost_in;
         rhop_ff      <= rhop_in;
      end
      s1_n_ff        <= s1_n_in;
      s1_d_ff        <= s1_d_in;
      s1_lc_ff       <= s1_lc_in;
      s1_skip_ff     <= s1_skip_in;
      s1_self_dst_ff <= s1_self_dst_in;
      s1_last_n_ff   <= s1_last_n_in;
      s1_last_d_ff   <= s1_last_d_in;
      best_ff        <= best_in;
      hop_ff         <= hop_in;
      rsp_dst_ff     <= rsp_dst_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_chg_ff     <= rsp_chg_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_route_destination = rsp_dst_ff;
   assign rsp_route_cost        = rsp_cost_ff;
   assign rsp_next_hop          = rsp_hop_ff;
   assign rsp_last_entry        = rsp_last_ff;
   assign rsp_table_changed     = rsp_chg_ff;

endmodule

// ===== src/dvr_checker.sv =====
module dvr_checker
   import dvr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_func,
   input logic              rsp_valid,
   input logic signed [7:0] rsp_route_cost,
   input logic              rsp_last_entry,
   input logic              rsp_table_changed
);

   // a recompute holds busy while it walks the pairs
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == FUNC_RECOMPUTE) |=> busy)
      else $error("recompute accepted but busy not raised");

   // change flag only rides on the final word
   a_chg_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_entry |-> !rsp_table_changed)
      else $error("table_changed set on a non-final word");

   // words of one pass are spaced, and a new pass cannot answer at once
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result words");

   a_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_route_cost == -8'sd1) ||
                    ((rsp_route_cost >= 8'sd0) && (rsp_route_cost <= 8'sd100)))
      else $error("route cost out of range");

endmodule

bind distance_vector_route_update_core dvr_checker u_dvr_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_route_cost   (rsp_route_cost),
   .rsp_last_entry   (rsp_last_entry),
   .rsp_table_changed(rsp_table_changed)
);
